[hw/rtl/assert_macros.svh]
// Shared assertion macros for the block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define CHK_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[hw/rtl/dle_pkg.sv]
`timescale 1ns / 1ps

package dle_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW       = $clog2(CAPACITY + 1);
    localparam int PW       = AW + 1;

    localparam int OPW = 4;
    localparam int VW  = 32;
    localparam int CW  = 7;
    localparam int SW  = 2;

    localparam int QAW    = 2;
    localparam int QDEPTH = 1 << QAW;

    localparam logic [OPW-1:0] OPC_PUSH_FRONT = 4'd0;
    localparam logic [OPW-1:0] OPC_PUSH_BACK  = 4'd1;
    localparam logic [OPW-1:0] OPC_POP_FRONT  = 4'd2;
    localparam logic [OPW-1:0] OPC_POP_BACK   = 4'd3;
    localparam logic [OPW-1:0] OPC_CLEAR      = 4'd4;
    localparam logic [OPW-1:0] OPC_REMOVE     = 4'd5;
    localparam logic [OPW-1:0] OPC_DUMP_ALL   = 4'd6;
    localparam logic [OPW-1:0] OPC_DUMP_FIRST = 4'd7;
    localparam logic [OPW-1:0] OPC_DUMP_LAST  = 4'd8;

    localparam logic [SW-1:0] STS_ELEM  = 2'd0;
    localparam logic [SW-1:0] STS_EMPTY = 2'd1;
    localparam logic [SW-1:0] STS_FULL  = 2'd2;

    typedef enum logic [3:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_CLEAR,
        OP_REMOVE,
        OP_DUMP_ALL,
        OP_DUMP_FIRST,
        OP_DUMP_LAST
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DUMP,
        S_SCAN,
        S_SHIFT
    } t_state;

    typedef struct packed {
        t_op                   op;
        logic signed [VW-1:0]  value;
        logic [CW-1:0]         count;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic vld;
    } t_qctl;

    // Map a logical position to its slot in the circular store.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [LW-1:0] k);
        logic [PW-1:0] sum;
        sum = PW'(head) + PW'(k);
        if (sum >= PW'(CAPACITY)) begin
            sum = sum - PW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

endpackage

[hw/rtl/dle_front.sv]
`timescale 1ns / 1ps

module dle_front import dle_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [OPW-1:0]       i_opcode,
    input  logic signed [VW-1:0] i_value,
    input  logic [CW-1:0]        i_count,
    input  logic                 i_q_full,
    output logic                 o_busy,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic r_vld, n_vld;
    t_cmd r_cmd;
    logic dec_ok;
    t_op  dec_op;
    logic accept;

    always_comb begin
        dec_ok = 1'b1;
        dec_op = OP_CLEAR;
        case (i_opcode)
            OPC_PUSH_FRONT: dec_op = OP_PUSH_FRONT;
            OPC_PUSH_BACK:  dec_op = OP_PUSH_BACK;
            OPC_POP_FRONT:  dec_op = OP_POP_FRONT;
            OPC_POP_BACK:   dec_op = OP_POP_BACK;
            OPC_CLEAR:      dec_op = OP_CLEAR;
            OPC_REMOVE:     dec_op = OP_REMOVE;
            OPC_DUMP_ALL:   dec_op = OP_DUMP_ALL;
            OPC_DUMP_FIRST: dec_op = OP_DUMP_FIRST;
            OPC_DUMP_LAST:  dec_op = OP_DUMP_LAST;
            default:        dec_ok = 1'b0;
        endcase
    end

    assign o_busy = r_vld && i_q_full;
    assign o_push = r_vld && !i_q_full;
    assign o_cmd  = r_cmd;
    assign accept = i_start && !o_busy;

    // Drop unused opcodes here so the back end never sees them.
    always_comb begin
        if (accept) begin
            n_vld = dec_ok;
        end else if (o_push) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && dec_ok) begin
            r_cmd.op    <= dec_op;
            r_cmd.value <= i_value;
            r_cmd.count <= i_count;
        end
    end

endmodule

[hw/rtl/dle_queue.sv]
`timescale 1ns / 1ps

module dle_queue import dle_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    input  logic  i_pop,
    output t_qctl o_ctl,
    output t_cmd  o_cmd
);

    t_cmd             r_slot [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QAW:0]     r_cnt, n_cnt;

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    assign o_ctl.full = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_ctl.vld  = (r_cnt != '0);
    assign o_cmd      = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

[hw/rtl/dle_back.sv]
`timescale 1ns / 1ps

module dle_back import dle_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_qctl                i_qctl,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    output logic                 o_strobe,
    output logic [SW-1:0]        o_status,
    output logic signed [VW-1:0] o_data,
    output logic                 o_last
);

    logic [VW-1:0] r_mem [CAPACITY];

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_idx, n_idx;
    logic [LW-1:0]   r_rem, n_rem;
    logic            r_chk_vld, n_chk_vld;
    logic [LW-1:0]   r_chk_idx, n_chk_idx;
    logic            r_wr_vld, n_wr_vld;
    logic [LW-1:0]   r_widx, n_widx;
    logic [VW-1:0]   r_val, n_val;
    logic            r_out_vld, n_out_vld;
    logic [SW-1:0]   r_out_status, n_out_status;
    logic            r_out_last, n_out_last;
    logic [VW-1:0]   r_rdata;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [VW-1:0]   mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [LW-1:0]   cnt_sat;
    logic [LW-1:0]   dump_n;
    logic [LW-1:0]   dump_start;
    logic            is_dump;

    always_comb begin
        cnt_sat = (i_cmd.count > CW'(r_len)) ? r_len : LW'(i_cmd.count);
        is_dump = 1'b0;
        dump_n  = r_len;
        dump_start = '0;
        case (i_cmd.op)
            OP_DUMP_ALL: begin
                is_dump = 1'b1;
            end
            OP_DUMP_FIRST: begin
                is_dump = 1'b1;
                dump_n  = cnt_sat;
            end
            OP_DUMP_LAST: begin
                is_dump    = 1'b1;
                dump_n     = cnt_sat;
                dump_start = r_len - cnt_sat;
            end
            default: begin
                is_dump = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_len        = r_len;
        n_idx        = r_idx;
        n_rem        = r_rem;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_wr_vld     = r_wr_vld;
        n_widx       = r_widx;
        n_val        = r_val;
        n_out_vld    = 1'b0;
        n_out_status = STS_ELEM;
        n_out_last   = 1'b0;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = phys(r_head, r_widx);
        mem_wdata    = r_rdata;
        mem_raddr    = phys(r_head, r_idx);

        case (r_state)
            S_IDLE: begin
                if (i_qctl.vld) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_PUSH_FRONT: begin
                            if (r_len == LW'(CAPACITY)) begin
                                n_out_vld    = 1'b1;
                                n_out_status = STS_FULL;
                                n_out_last   = 1'b1;
                            end else begin
                                n_head    = phys(r_head, LW'(CAPACITY - 1));
                                mem_we    = 1'b1;
                                mem_waddr = n_head;
                                mem_wdata = i_cmd.value;
                                n_len     = r_len + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (r_len == LW'(CAPACITY)) begin
                                n_out_vld    = 1'b1;
                                n_out_status = STS_FULL;
                                n_out_last   = 1'b1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = phys(r_head, r_len);
                                mem_wdata = i_cmd.value;
                                n_len     = r_len + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (r_len != '0) begin
                                n_head = phys(r_head, LW'(1));
                                n_len  = r_len - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (r_len != '0) begin
                                n_len = r_len - 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_len = '0;
                        end
                        OP_REMOVE: begin
                            n_val     = i_cmd.value;
                            n_idx     = '0;
                            n_chk_vld = 1'b0;
                            n_state   = S_SCAN;
                        end
                        default: begin
                            if (is_dump) begin
                                if (dump_n == '0) begin
                                    n_out_vld    = 1'b1;
                                    n_out_status = STS_EMPTY;
                                    n_out_last   = 1'b1;
                                end else begin
                                    n_idx   = dump_start;
                                    n_rem   = dump_n;
                                    n_state = S_DUMP;
                                end
                            end
                        end
                    endcase
                end
            end
            S_DUMP: begin
                // One read per cycle; the word goes out as the data lands.
                n_out_vld  = 1'b1;
                n_out_last = (r_rem == LW'(1));
                n_idx      = r_idx + 1'b1;
                n_rem      = r_rem - 1'b1;
                if (r_rem == LW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_chk_vld && (r_rdata == r_val)) begin
                    n_idx     = r_chk_idx + 1'b1;
                    n_chk_vld = 1'b0;
                    n_wr_vld  = 1'b0;
                    n_state   = S_SHIFT;
                end else if (r_idx == r_len) begin
                    n_chk_vld = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_idx;
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_SHIFT: begin
                // Copy each entry one slot toward the front of the hole.
                mem_we = r_wr_vld;
                if (r_idx < r_len) begin
                    n_widx   = r_idx - 1'b1;
                    n_wr_vld = 1'b1;
                    n_idx    = r_idx + 1'b1;
                end else begin
                    n_wr_vld = 1'b0;
                    n_len    = r_len - 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_len     <= '0;
            r_chk_vld <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_len     <= n_len;
            r_chk_vld <= n_chk_vld;
            r_wr_vld  <= n_wr_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_rem        <= n_rem;
        r_chk_idx    <= n_chk_idx;
        r_widx       <= n_widx;
        r_val        <= n_val;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_strobe = r_out_vld;
    assign o_status = r_out_status;
    assign o_data   = (r_out_status == STS_ELEM) ? r_rdata : '0;
    assign o_last   = r_out_last;

endmodule

[hw/rtl/deque_list_engine_core.sv]
`timescale 1ns / 1ps
// An accepted command is registered in the front end, waits in the command queue and
// is popped by the executor; a dropped push, an empty dump line and each dumped word
// are registered at the output. Push, pop, clear and an empty dump finish in the idle
// state; a dump reads the entry memory once per word; remove scans, shifting on a match.
// A 4-deep command queue lets start be taken while the executor works.
// Reset: synchronous, active low; empties the list and the queue, no memory sweep.

module deque_list_engine_core import dle_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OPW-1:0]       i_opcode,
    input  logic signed [VW-1:0] i_value,
    input  logic [CW-1:0]        i_count,
    output logic                 o_strobe,
    output logic [SW-1:0]        o_status,
    output logic signed [VW-1:0] o_data,
    output logic                 o_last
);

    t_qctl q_ctl;
    t_cmd  f_cmd;
    t_cmd  q_cmd;
    logic  f_push;
    logic  b_pop;

    dle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_value  (i_value),
        .i_count  (i_count),
        .i_q_full (q_ctl.full),
        .o_busy   (busy),
        .o_push   (f_push),
        .o_cmd    (f_cmd)
    );

    dle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (b_pop),
        .o_ctl   (q_ctl),
        .o_cmd   (q_cmd)
    );

    dle_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qctl   (q_ctl),
        .i_cmd    (q_cmd),
        .o_pop    (b_pop),
        .o_strobe (o_strobe),
        .o_status (o_status),
        .o_data   (o_data),
        .o_last   (o_last)
    );

endmodule

[hw/rtl/dle_chk.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dle_chk import dle_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_strobe,
    input logic [SW-1:0]        o_status,
    input logic signed [VW-1:0] o_data,
    input logic                 o_last
);

    `CHK_ASSERT(a_side_word_last, i_clk, i_rst_n, (o_strobe && o_status != STS_ELEM) |-> o_last, "status word without last mark")
    `CHK_ASSERT(a_side_word_zero, i_clk, i_rst_n, (o_strobe && o_status != STS_ELEM) |-> (o_data == '0), "status word with nonzero data")
    `CHK_NEVER(a_status_code, i_clk, i_rst_n, o_strobe && o_status != STS_ELEM && o_status != STS_EMPTY && o_status != STS_FULL, "undefined status code")
    `CHK_ASSERT(a_dump_burst, i_clk, i_rst_n, (o_strobe && !o_last) |=> (o_strobe && o_status == STS_ELEM), "gap inside dump burst")

endmodule

bind deque_list_engine_core dle_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_strobe (o_strobe),
    .o_status (o_status),
    .o_data   (o_data),
    .o_last   (o_last)
);
